// ===== sv/rkpc_pkg.sv =====
package rkpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTENS_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FX_LIMIT    = 3'd5;

	localparam logic [7:0]  RST_STEP      = 8'd4;
	localparam logic [15:0] RST_LONG_HOLD = 16'd1000;
	localparam logic [7:0]  VALUE_MAX     = 8'd255;

	localparam logic [2:0] MODE_BRIGHT = 3'd0;
	localparam logic [2:0] MODE_SPEED  = 3'd1;
	localparam logic [2:0] MODE_INTENS = 3'd2;
	localparam logic [2:0] MODE_PAL    = 3'd3;
	localparam logic [2:0] MODE_FX     = 3'd4;
	localparam logic [3:0] MODE_COUNT  = 4'd5;

	typedef struct packed {
		logic [7:0]  bright_step;
		logic [7:0]  speed_step;
		logic [7:0]  intens_step;
		logic [15:0] long_hold_ms;
		logic [7:0]  pal_limit;
		logic [7:0]  fx_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] knob_position;
		logic               button_down;
		logic [31:0]        time_ms;
		logic               display_asleep;
	} item_t;

	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] speed;
		logic [7:0] intensity;
		logic [7:0] palette;
		logic [7:0] effect;
		logic [2:0] knob_mode;
		logic       power_toggle;
		logic       value_changed;
		logic       mode_advanced;
	} result_t;

endpackage

// ===== sv/rkpc_cfg.sv =====
module rkpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_en,
	input  logic [rkpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rkpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output rkpc_pkg::cfg_t                 cfg
);
	import rkpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_step  <= RST_STEP;
			cfg_q.speed_step   <= RST_STEP;
			cfg_q.intens_step  <= RST_STEP;
			cfg_q.long_hold_ms <= RST_LONG_HOLD;
			cfg_q.pal_limit    <= VALUE_MAX;
			cfg_q.fx_limit     <= VALUE_MAX;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_BRIGHT_STEP: cfg_q.bright_step  <= cfg_data[7:0];
				REG_SPEED_STEP:  cfg_q.speed_step   <= cfg_data[7:0];
				REG_INTENS_STEP: cfg_q.intens_step  <= cfg_data[7:0];
				REG_LONG_HOLD:   cfg_q.long_hold_ms <= cfg_data;
				REG_PAL_LIMIT:   cfg_q.pal_limit    <= cfg_data[7:0];
				REG_FX_LIMIT:    cfg_q.fx_limit     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/rkpc_core.sv =====
module rkpc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  rkpc_pkg::cfg_t    cfg,
	input  rkpc_pkg::item_t   item,
	input  logic              adv,
	output rkpc_pkg::result_t res
);
	import rkpc_pkg::*;

	logic [15:0] prev_pos_q;
	logic        prev_btn_q;
	logic        consumed_q;
	logic [31:0] press_start_q;
	logic [2:0]  mode_q;
	logic [7:0]  bright_q, speed_q, intens_q, pal_q, fx_q;

	logic signed [15:0] delta;
	logic               rot, woke_by_rot, apply, mode_ok;
	logic [7:0]         step_sel, val_sel, hi_sel, new_val;
	logic signed [24:0] prod;
	logic signed [25:0] sum;
	logic               press_edge, release_edge, hold_done;
	logic               toggle, advance, consumed_nx;
	logic [3:0]         mode_inc;
	logic [2:0]         mode_nx;
	logic [7:0]         bright_nx, speed_nx, intens_nx, pal_nx, fx_nx;

	assign delta       = $signed(item.knob_position - prev_pos_q);
	assign rot         = delta != 16'sd0;
	assign woke_by_rot = rot && item.display_asleep;
	assign apply       = rot && !item.display_asleep;

	always_comb begin
		mode_ok  = 1'b1;
		step_sel = 8'd1;
		val_sel  = 8'd0;
		hi_sel   = VALUE_MAX;
		unique case (mode_q)
			MODE_BRIGHT: begin
				step_sel = cfg.bright_step;
				val_sel  = bright_q;
			end
			MODE_SPEED: begin
				step_sel = cfg.speed_step;
				val_sel  = speed_q;
			end
			MODE_INTENS: begin
				step_sel = cfg.intens_step;
				val_sel  = intens_q;
			end
			MODE_PAL: begin
				val_sel = pal_q;
				hi_sel  = cfg.pal_limit;
			end
			MODE_FX: begin
				val_sel = fx_q;
				hi_sel  = cfg.fx_limit;
			end
			default: mode_ok = 1'b0;
		endcase
	end

	assign prod = 25'(delta) * 25'($signed({1'b0, step_sel}));
	assign sum  = 26'(prod) + $signed({18'd0, val_sel});

	always_comb begin
		priority if (sum < 26'sd0) begin
			new_val = 8'd0;
		end else if (sum > $signed({18'd0, hi_sel})) begin
			new_val = hi_sel;
		end else begin
			new_val = sum[7:0];
		end
	end

	always_comb begin
		bright_nx = bright_q;
		speed_nx  = speed_q;
		intens_nx = intens_q;
		pal_nx    = pal_q;
		fx_nx     = fx_q;
		if (apply) begin
			unique case (mode_q)
				MODE_BRIGHT: bright_nx = new_val;
				MODE_SPEED:  speed_nx  = new_val;
				MODE_INTENS: intens_nx = new_val;
				MODE_PAL:    pal_nx    = new_val;
				MODE_FX:     fx_nx     = new_val;
				default: ;
			endcase
		end
	end

	// press and release handling
	assign press_edge   = item.button_down && !prev_btn_q;
	assign release_edge = !item.button_down && prev_btn_q;
	assign hold_done    = (item.time_ms - press_start_q) >= {16'd0, cfg.long_hold_ms};
	assign mode_inc     = {1'b0, mode_q} + 4'd1;

	always_comb begin
		toggle      = 1'b0;
		advance     = 1'b0;
		consumed_nx = consumed_q;
		mode_nx     = mode_q;
		priority if (press_edge) begin
			consumed_nx = item.display_asleep && !woke_by_rot;
		end else if (item.button_down && !consumed_q && hold_done) begin
			toggle      = 1'b1;
			consumed_nx = 1'b1;
		end else if (release_edge && !consumed_q) begin
			advance = 1'b1;
			mode_nx = (mode_inc >= MODE_COUNT) ? 3'(mode_inc - MODE_COUNT) : mode_inc[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q    <= '0;
			prev_btn_q    <= 1'b0;
			consumed_q    <= 1'b0;
			press_start_q <= '0;
			mode_q        <= MODE_BRIGHT;
			bright_q      <= '0;
			speed_q       <= '0;
			intens_q      <= '0;
			pal_q         <= '0;
			fx_q          <= '0;
		end else if (adv) begin
			prev_pos_q <= item.knob_position;
			prev_btn_q <= item.button_down;
			consumed_q <= consumed_nx;
			if (press_edge) begin
				press_start_q <= item.time_ms;
			end
			mode_q   <= mode_nx;
			bright_q <= bright_nx;
			speed_q  <= speed_nx;
			intens_q <= intens_nx;
			pal_q    <= pal_nx;
			fx_q     <= fx_nx;
		end
	end

	always_comb begin
		res.brightness    = bright_nx;
		res.speed         = speed_nx;
		res.intensity     = intens_nx;
		res.palette       = pal_nx;
		res.effect        = fx_nx;
		res.knob_mode     = mode_nx;
		res.power_toggle  = toggle;
		res.value_changed = apply && mode_ok;
		res.mode_advanced = advance;
	end

`ifndef SYNTHESIS
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_FX)
		else $error("mode register out of range");
	a_consumed_after_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && toggle |=> consumed_q)
		else $error("long press not marked consumed");
`endif

endmodule

// ===== sv/rotary_knob_parameter_controller_top.sv =====
// path: an accepted word is held in stage one, and its result is then registered on the outputs
// throughput: one word per cycle, sustained as long as the result side does not stall
// the rate is set by the single registered update of the knob state per word
// reset: arst_n clears the knob state and the valid bits of both stages at once, config registers
// return to their defaults (steps 4, hold 1000 ms, limits 255)
module rotary_knob_parameter_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             knob_position,
	input  logic                           button_down,
	input  logic [31:0]                    time_ms,
	input  logic                           display_asleep,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     brightness,
	output logic [7:0]                     speed,
	output logic [7:0]                     intensity,
	output logic [7:0]                     palette,
	output logic [7:0]                     effect,
	output logic [2:0]                     knob_mode,
	output logic                           power_toggle,
	output logic                           value_changed,
	output logic                           mode_advanced,
	input  logic                           cfg_en,
	input  logic [rkpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rkpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rkpc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	rkpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rkpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv),
		.res    (res)
	);

	// stage one moves on when the output register is free or being taken
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.knob_position  <= knob_position;
			item_s1.button_down    <= button_down;
			item_s1.time_ms        <= time_ms;
			item_s1.display_asleep <= display_asleep;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign brightness    = res_q.brightness;
	assign speed         = res_q.speed;
	assign intensity     = res_q.intensity;
	assign palette       = res_q.palette;
	assign effect        = res_q.effect;
	assign knob_mode     = res_q.knob_mode;
	assign power_toggle  = res_q.power_toggle;
	assign value_changed = res_q.value_changed;
	assign mode_advanced = res_q.mode_advanced;

`ifndef SYNTHESIS
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced word missing from output register");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.power_toggle && res_q.mode_advanced))
		else $error("toggle and mode advance in one word");
`endif

endmodule
